/* sv/oah_pkg.sv */
// ----------------------------------------------------------------------------
// oah_pkg: shared types and constants
// Codes, field widths and register defaults of the open-addressing hash insert
// block.
// ----------------------------------------------------------------------------
package oah_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int SIZE_W   = 6;
    localparam int SMOD_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd32;
    localparam logic [MODE_W-1:0]  MODE_RESET = 2'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 6'd17;
    localparam logic [SMOD_W-1:0]  SMOD_RESET = 5'd13;

    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;

    localparam logic [MODE_W-1:0] PM_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] PM_DOUBLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOD       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HOME    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PROBED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ    = 3'd4;

    typedef struct packed {
        logic start;
        logic short_run;
    } t_mod_ctrl;

    // one compare and subtract, valid while x < 2*m
    function automatic logic [SIZE_W-1:0] mod_sub(logic [SIZE_W:0] x, logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] d;
        d = x - {1'b0, m};
        return (x >= {1'b0, m}) ? d[SIZE_W-1:0] : x[SIZE_W-1:0];
    endfunction

endpackage

/* sv/oah_mod_unit.sv */
// ----------------------------------------------------------------------------
// oah_mod_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle, remainder only. A short run
// takes only the top SMOD_W bits of the dividend.
// ----------------------------------------------------------------------------
module oah_mod_unit #(
    parameter int KEY_WIDTH = oah_pkg::KEY_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  oah_pkg::t_mod_ctrl        i_ctrl,
    input  logic [KEY_WIDTH-1:0]      i_dividend,
    input  logic [oah_pkg::SIZE_W-1:0] i_modulus,
    output logic                      o_done,
    output logic [oah_pkg::SIZE_W-1:0] o_rem
);
    import oah_pkg::*;

    localparam int CNT_W = $clog2(KEY_WIDTH + 1);

    logic [KEY_WIDTH-1:0] r_dvd;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_m;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [SIZE_W:0]      trial;

    assign trial = {r_rem, r_dvd[KEY_WIDTH-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_ctrl.short_run ? CNT_W'(SMOD_W) : CNT_W'(KEY_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_m   <= i_modulus;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_WIDTH-2:0], 1'b0};
            r_rem <= mod_sub(trial, r_m);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sv/open_addressing_hash_insert.sv */
// ----------------------------------------------------------------------------
// open_addressing_hash_insert: open-addressing hash table insert and read
// Clears the table, inserts a signed key by linear, quadratic or double-hash
// probing, or reads one slot; counts inserts placed after probing.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tuser func; tdata key, slot_index
//  m_*       out        tuser status; tdata slot, entry_key, entry_valid,
//                       displaced_inserts
//  i_cfg_*   in         write enable, register index, write data
//
//  clear goes from accept straight to the result; read passes through S_READ.
//  insert: a full remainder run gives the home slot, then the home check and any
//  probing follow; double hashing adds a full and a short remainder run for the
//  step, all on the bit-serial remainder unit. s_tready is high only while no item is at work.
//  valid bits are flip-flops cleared at once by reset or by a clear item.
//  a result waits in the output register while m_tready is low.
module open_addressing_hash_insert #(
    parameter int TABLE_DEPTH = oah_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = oah_pkg::KEY_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // func
    input  logic [oah_pkg::FUNC_W-1:0] s_tuser,
    // key, slot_index
    input  logic [((KEY_WIDTH + oah_pkg::SLOT_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status
    output logic [oah_pkg::STATUS_W-1:0] m_tuser,
    // slot, entry_key, entry_valid, displaced_inserts
    output logic [((KEY_WIDTH + oah_pkg::SLOT_W + 1 + oah_pkg::COUNT_W + 7) / 8) * 8 - 1:0]
        m_tdata,
    input  logic i_cfg_we,
    input  logic [oah_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [oah_pkg::CFG_W-1:0] i_cfg_data
);
    import oah_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int DW_OUT = ((KEY_WIDTH + SLOT_W + 1 + COUNT_W + 7) / 8) * 8;
    localparam logic [SIZE_W-1:0] DEPTH_CAP =
        (TABLE_DEPTH > (1 << SIZE_W) - 1) ? SIZE_W'((1 << SIZE_W) - 1) : SIZE_W'(TABLE_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DIV_HOME = 8'b0000_0010,
        S_HOME     = 8'b0000_0100,
        S_DIV_R    = 8'b0000_1000,
        S_DIV_N    = 8'b0001_0000,
        S_PROBE    = 8'b0010_0000,
        S_READ     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0]  r_mode;
    logic [SIZE_W-1:0]  r_size;
    logic [SMOD_W-1:0]  r_smod;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [KEY_WIDTH-1:0]   r_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   r_rd;
    logic                   r_hit;
    logic [COUNT_W-1:0]     r_probe_cnt;

    logic [KEY_WIDTH-1:0] r_key;
    logic [SIZE_W-1:0]    r_n;
    logic [SIZE_W-1:0]    r_pos;
    logic [SIZE_W-1:0]    r_inc;
    logic [SIZE_W-1:0]    r_step;
    logic [SIZE_W-1:0]    r_i;

    logic [STATUS_W-1:0]  r_res_status;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [KEY_WIDTH-1:0] r_res_key;
    logic                 r_res_ev;

    logic                 r_m_valid;
    logic [STATUS_W-1:0]  r_m_status;
    logic [SLOT_W-1:0]    r_m_slot;
    logic [KEY_WIDTH-1:0] r_m_key;
    logic                 r_m_ev;
    logic [COUNT_W-1:0]   r_m_disp;

    logic                 s_acc;
    logic [FUNC_W-1:0]    in_func;
    logic [KEY_WIDTH-1:0] in_key;
    logic [SLOT_W-1:0]    in_sidx;
    logic [KEY_WIDTH-1:0] in_mag, key_mag;
    logic [SIZE_W-1:0]    size_eff;
    logic [SIZE_W-1:0]    smod_eff;
    logic [AW+SLOT_W-1:0] sidx_w;
    logic [AW-1:0]        rd_addr;
    logic                 rd_in_range;
    logic [AW+SIZE_W-1:0] pos_w, cand_w;
    logic [AW-1:0]        pos_addr, cand_addr;
    logic [SIZE_W-1:0]    add_amt, cand;
    logic [SIZE_W-1:0]    fixed_rem;
    logic [SMOD_W-1:0]    step_s;
    logic [SIZE_W:0]      inc_sum;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;

    t_mod_ctrl            mod_ctrl;
    logic [KEY_WIDTH-1:0] mod_dvd;
    logic [SIZE_W-1:0]    mod_m;
    logic                 mod_done;
    logic [SIZE_W-1:0]    mod_rem;

    assign in_func = s_tuser;
    assign in_key  = s_tdata[KEY_WIDTH-1:0];
    assign in_sidx = s_tdata[KEY_WIDTH+SLOT_W-1:KEY_WIDTH];

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign in_mag  = in_key[KEY_WIDTH-1] ? (~in_key + 1'b1) : in_key;
    assign key_mag = r_key[KEY_WIDTH-1] ? (~r_key + 1'b1) : r_key;

    assign size_eff = (r_size == '0) ? SIZE_W'(1) :
                      ((r_size > DEPTH_CAP) ? DEPTH_CAP : r_size);
    assign smod_eff = (r_smod == '0) ? SIZE_W'(1) : {1'b0, r_smod};

    assign sidx_w      = {{AW{1'b0}}, in_sidx};
    assign rd_addr     = sidx_w[AW-1:0];
    assign rd_in_range = sidx_w < (AW + SLOT_W)'(TABLE_DEPTH);

    assign pos_w    = {{AW{1'b0}}, r_pos};
    assign pos_addr = pos_w[AW-1:0];

    always_comb begin
        case (r_mode)
            PM_QUAD:   add_amt = r_inc;
            PM_DOUBLE: add_amt = r_step;
            default:   add_amt = SIZE_W'(1);
        endcase
    end

    assign cand      = mod_sub({1'b0, r_pos} + {1'b0, add_amt}, r_n);
    assign cand_w    = {{AW{1'b0}}, cand};
    assign cand_addr = cand_w[AW-1:0];
    assign inc_sum   = {1'b0, r_inc} + (SIZE_W + 1)'(2);

    // non-negative remainder of a signed key
    always_comb begin
        fixed_rem = mod_rem;
        if (r_key[KEY_WIDTH-1] && mod_rem != '0) begin
            fixed_rem = ((r_state == S_DIV_R) ? smod_eff : r_n) - mod_rem;
        end
    end
    assign step_s = SMOD_W'(smod_eff - fixed_rem);

    always_comb begin
        mod_ctrl  = '0;
        mod_dvd   = in_mag;
        mod_m     = size_eff;
        case (r_state)
            S_IDLE: begin
                mod_ctrl.start = s_acc && (in_func == FN_INSERT);
            end
            S_HOME: begin
                mod_ctrl.start = r_valid[pos_addr] && (r_mode == PM_DOUBLE);
                mod_dvd        = key_mag;
                mod_m          = smod_eff;
            end
            S_DIV_R: begin
                mod_ctrl.start     = mod_done;
                mod_ctrl.short_run = 1'b1;
                mod_dvd            = {step_s, {(KEY_WIDTH - SMOD_W){1'b0}}};
                mod_m              = r_n;
            end
            default: begin
                mod_ctrl = '0;
            end
        endcase
    end

    oah_mod_unit #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (mod_ctrl),
        .i_dividend (mod_dvd),
        .i_modulus  (mod_m),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (in_func == FN_CLEAR) begin
                        n_state = S_DONE;
                    end else if (in_func == FN_INSERT) begin
                        n_state = S_DIV_HOME;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_DIV_HOME: begin
                if (mod_done) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (!r_valid[pos_addr]) begin
                    n_state = S_DONE;
                end else if (r_mode == PM_DOUBLE) begin
                    n_state = S_DIV_R;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_DIV_R: begin
                if (mod_done) begin
                    n_state = S_DIV_N;
                end
            end
            S_DIV_N: begin
                if (mod_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!r_valid[cand_addr] || r_i == r_n) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pos_addr;
        if (r_state == S_HOME && !r_valid[pos_addr]) begin
            mem_we = 1'b1;
        end else if (r_state == S_PROBE && !r_valid[cand_addr]) begin
            mem_we    = 1'b1;
            mem_waddr = cand_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_key;
        end
        if (s_acc) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_RESET;
            r_size      <= SIZE_RESET;
            r_smod      <= SMOD_RESET;
            r_valid     <= '0;
            r_probe_cnt <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROBE_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_SIZE:       r_size <= i_cfg_data[SIZE_W-1:0];
                    CFG_SMOD:       r_smod <= i_cfg_data[SMOD_W-1:0];
                    default:        r_mode <= r_mode;
                endcase
            end
            if (s_acc && in_func == FN_CLEAR) begin
                r_valid     <= '0;
                r_probe_cnt <= '0;
            end else if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (r_state == S_PROBE && !r_valid[cand_addr] && r_probe_cnt < COUNT_MAX) begin
                r_probe_cnt <= r_probe_cnt + 1'b1;
            end
            if (r_state == S_DONE && (!r_m_valid || m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_key        <= in_key;
                r_n          <= size_eff;
                r_hit        <= rd_in_range && r_valid[rd_addr];
                r_res_slot   <= (in_func == FN_CLEAR || in_func == FN_INSERT) ? '0 : in_sidx;
                r_res_key    <= '0;
                r_res_ev     <= 1'b0;
                r_res_status <= (in_func == FN_CLEAR) ? ST_CLEARED : ST_FAIL;
            end
            S_DIV_HOME: begin
                if (mod_done) begin
                    r_pos <= fixed_rem;
                end
            end
            S_HOME: begin
                r_i   <= SIZE_W'(1);
                r_inc <= (r_n == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                r_step <= SIZE_W'(1);
                if (!r_valid[pos_addr]) begin
                    r_res_status <= ST_HOME;
                    r_res_slot   <= r_pos[SLOT_W-1:0];
                end
            end
            S_DIV_N: begin
                if (mod_done) begin
                    r_step <= mod_rem;
                end
            end
            S_PROBE: begin
                r_pos <= cand;
                r_i   <= r_i + 1'b1;
                r_inc <= (r_n == SIZE_W'(1)) ? '0 : mod_sub(inc_sum, r_n);
                if (!r_valid[cand_addr]) begin
                    r_res_status <= ST_PROBED;
                    r_res_slot   <= cand[SLOT_W-1:0];
                end
            end
            S_READ: begin
                r_res_status <= ST_READ;
                r_res_key    <= r_hit ? r_rd : '0;
                r_res_ev     <= r_hit;
            end
            default: begin
                r_res_ev <= r_res_ev;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_m_valid || m_tready)) begin
            r_m_status <= r_res_status;
            r_m_slot   <= r_res_slot;
            r_m_key    <= r_res_key;
            r_m_ev     <= r_res_ev;
            r_m_disp   <= r_probe_cnt;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_status;
    assign m_tdata  = DW_OUT'({r_m_disp, r_m_ev, r_m_key, r_m_slot});

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_tready)
        else $error("input accepted while an item is at work");

    a_counter_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probe_cnt <= COUNT_MAX)
        else $error("probe counter beyond saturation");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status == ST_CLEARED) |-> (r_m_disp == '0 && !r_m_ev))
        else $error("clear result carries stale fields");

    a_probe_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_i >= SIZE_W'(1) && r_i <= r_n && r_pos < r_n))
        else $error("probe position or index out of range");

endmodule
